@@ sv/tabular_q_learning_update_top_macros.svh @@
// assertion helpers for the q table update block
`ifndef TABULAR_Q_LEARNING_UPDATE_TOP_MACROS_SVH
`define TABULAR_Q_LEARNING_UPDATE_TOP_MACROS_SVH

// checked only outside reset
`define TQLU_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// checked on every edge, reset included
`define TQLU_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ sv/tqlu_pkg.sv @@
package tqlu_pkg;

   localparam int STATE_COUNT_DEF  = 16;
   localparam int ACTION_COUNT_DEF = 4;

   localparam int STATE_W  = 4;
   localparam int ACTION_W = 2;
   localparam int VALUE_W  = 32;
   localparam int CFG_W    = 16;
   localparam int FRAC_W   = 16;

   // arithmetic widths
   localparam int BEST_W  = VALUE_W - 1;
   localparam int GPROD_W = CFG_W + BEST_W;
   localparam int G_W     = GPROD_W + 1 - FRAC_W;
   localparam int DIFF_W  = VALUE_W + 2;
   localparam int APROD_W = CFG_W + 1 + DIFF_W;
   localparam int DELTA_W = APROD_W - FRAC_W;
   localparam int SUM_W   = DELTA_W + 1;

   localparam int ROUND_HALF = 32768;

   localparam logic [CFG_W-1:0] LEARNING_RATE_RESET   = 16'd6554;
   localparam logic [CFG_W-1:0] DISCOUNT_FACTOR_RESET = 16'd62259;

   localparam logic [VALUE_W-1:0] Q_MAX = 32'h7FFF_FFFF;
   localparam logic [VALUE_W-1:0] Q_MIN = 32'h8000_0000;

   typedef enum logic {
      CMD_UPDATE = 1'b0,
      CMD_READ   = 1'b1
   } cmd_type;

   typedef enum logic [0:0] {
      CSR_LEARNING_RATE   = 1'd0,
      CSR_DISCOUNT_FACTOR = 1'd1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FETCH,
      ST_SCALE,
      ST_DIFF,
      ST_MULT,
      ST_APPLY
   } fsm_state_type;

   typedef struct packed {
      cmd_type                    command;
      logic [STATE_W-1:0]         current_state;
      logic [ACTION_W-1:0]        chosen_action;
      logic signed [VALUE_W-1:0]  reward_value;
      logic [STATE_W-1:0]         following_state;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0]  entry_value;
      logic                       saturated;
   } rsp_type;

   typedef struct packed {
      logic clearing;
      logic load;
      logic take_cur;
      logic fold;
      logic read_out;
      logic scale;
      logic diff;
      logic mult;
      logic apply;
   } ctl_type;

endpackage

@@ sv/tqlu_ram.sv @@
module tqlu_ram #(
   parameter int  WIDTH  = 32,
   parameter int  DEPTH  = 64,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/tqlu_seq.sv @@
module tqlu_seq #(
   parameter int  STATE_COUNT  = tqlu_pkg::STATE_COUNT_DEF,
   parameter int  ACTION_COUNT = tqlu_pkg::ACTION_COUNT_DEF,
   localparam int DEPTH        = STATE_COUNT * ACTION_COUNT,
   localparam int ADDR_W       = $clog2(DEPTH)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  tqlu_pkg::req_type   req_data,
   output logic                busy,
   output tqlu_pkg::ctl_type   ctl,
   output logic [ADDR_W-1:0]   rd_addr,
   output logic                wr_en,
   output logic [ADDR_W-1:0]   wr_addr
);

   import tqlu_pkg::*;

   localparam int COL_W    = $clog2(ACTION_COUNT + 1);
   localparam int STATE_N  = 1 << STATE_W;
   localparam int ACTION_N = 1 << ACTION_W;

   // index wrap folded into constant tables
   logic [ADDR_W-1:0] row_base_tbl [STATE_N];
   logic [ADDR_W-1:0] act_tbl      [ACTION_N];

   for (genvar v = 0; v < STATE_N; v++) begin : g_row
      localparam int BASE = (v % STATE_COUNT) * ACTION_COUNT;
      assign row_base_tbl[v] = ADDR_W'(BASE);
   end

   for (genvar w = 0; w < ACTION_N; w++) begin : g_act
      localparam int OFS = w % ACTION_COUNT;
      assign act_tbl[w] = ADDR_W'(OFS);
   end

   fsm_state_type     state_ff, state_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ADDR_W-1:0] clr_ff, clr_in;
   logic [ADDR_W-1:0] idx_ff, idx_in;
   logic [ADDR_W-1:0] nrow_ff, nrow_in;
   cmd_type           cmd_ff, cmd_in;

   logic [ADDR_W-1:0] req_idx;
   logic [ADDR_W-1:0] fetch_addr;

   assign req_idx = row_base_tbl[req_data.current_state]
                    + act_tbl[req_data.chosen_action];

   // the last fetch cycle only drains the read pipe
   assign fetch_addr = (col_ff < COL_W'(ACTION_COUNT)) ? nrow_ff + ADDR_W'(col_ff) : nrow_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         col_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         col_ff   <= col_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      nrow_ff <= nrow_in;
      cmd_ff  <= cmd_in;
   end

   always_comb begin
      state_in = state_ff;
      col_in   = col_ff;
      clr_in   = clr_ff;
      idx_in   = idx_ff;
      nrow_in  = nrow_ff;
      cmd_in   = cmd_ff;
      ctl      = '0;
      rd_addr  = fetch_addr;
      wr_en    = 1'b0;
      wr_addr  = idx_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            ctl.clearing = 1'b1;
            wr_en        = 1'b1;
            wr_addr      = clr_ff;
            if (clr_ff == ADDR_W'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end else begin
               clr_in = clr_ff + ADDR_W'(1);
            end
         end
         ST_IDLE: begin
            rd_addr = req_idx;
            if (start) begin
               ctl.load = 1'b1;
               idx_in   = req_idx;
               nrow_in  = row_base_tbl[req_data.following_state];
               cmd_in   = req_data.command;
               col_in   = '0;
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            if (col_ff == '0) begin
               ctl.take_cur = 1'b1;
               if (cmd_ff == CMD_READ) begin
                  ctl.read_out = 1'b1;
                  state_in     = ST_IDLE;
               end else begin
                  col_in = col_ff + COL_W'(1);
               end
            end else begin
               ctl.fold = 1'b1;
               if (col_ff == COL_W'(ACTION_COUNT)) begin
                  state_in = ST_SCALE;
               end else begin
                  col_in = col_ff + COL_W'(1);
               end
            end
         end
         ST_SCALE: begin
            ctl.scale = 1'b1;
            state_in  = ST_DIFF;
         end
         ST_DIFF: begin
            ctl.diff = 1'b1;
            state_in = ST_MULT;
         end
         ST_MULT: begin
            ctl.mult = 1'b1;
            state_in = ST_APPLY;
         end
         ST_APPLY: begin
            ctl.apply = 1'b1;
            wr_en     = 1'b1;
            wr_addr   = idx_ff;
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
            clr_in   = '0;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

@@ sv/tqlu_arith.sv @@
module tqlu_arith (
   input  logic                                 clock,
   input  logic                                 reset,
   input  tqlu_pkg::ctl_type                    ctl,
   input  logic signed [tqlu_pkg::VALUE_W-1:0]  reward_value,
   input  logic [tqlu_pkg::VALUE_W-1:0]         rd_data,
   input  logic [tqlu_pkg::CFG_W-1:0]           learning_rate,
   input  logic [tqlu_pkg::CFG_W-1:0]           discount_factor,
   output logic [tqlu_pkg::VALUE_W-1:0]         wr_value,
   output logic                                 rsp_valid,
   output tqlu_pkg::rsp_type                    rsp_data
);

   import tqlu_pkg::*;

   logic signed [VALUE_W-1:0] reward_ff;
   logic signed [VALUE_W-1:0] cur_ff;
   logic [BEST_W-1:0]         best_ff, best_in;
   logic [GPROD_W-1:0]        gprod_ff, gprod_in;
   logic signed [DIFF_W-1:0]  diff_ff, diff_in;
   logic signed [APROD_W-1:0] aprod_ff, aprod_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_type                   rsp_data_ff, rsp_data_in;

   logic [GPROD_W:0]          gsum;
   logic [G_W-1:0]            g_val;
   logic signed [CFG_W:0]     alpha_s;
   logic signed [APROD_W-1:0] rnd;
   logic signed [DELTA_W-1:0] delta_val;
   logic signed [SUM_W-1:0]   sum_val;
   logic [SUM_W-VALUE_W:0]    upper;
   logic                      sat;

   // running max of the next row, floored at zero
   assign best_in = (!rd_data[VALUE_W-1] && (rd_data[BEST_W-1:0] > best_ff))
                    ? rd_data[BEST_W-1:0] : best_ff;

   assign gprod_in = GPROD_W'(discount_factor) * GPROD_W'(best_ff);

   // round to nearest, ties upward
   assign gsum    = {1'b0, gprod_ff} + (GPROD_W + 1)'(ROUND_HALF);
   assign g_val   = gsum[GPROD_W:FRAC_W];
   assign diff_in = DIFF_W'(reward_ff) + DIFF_W'(g_val) - DIFF_W'(cur_ff);

   assign alpha_s  = signed'({1'b0, learning_rate});
   assign aprod_in = APROD_W'(alpha_s) * APROD_W'(diff_ff);

   assign rnd       = aprod_ff + APROD_W'(ROUND_HALF);
   assign delta_val = rnd[APROD_W-1:FRAC_W];
   assign sum_val   = SUM_W'(cur_ff) + SUM_W'(delta_val);
   assign upper     = sum_val[SUM_W-1:VALUE_W-1];
   assign sat       = !((upper == '0) || (upper == '1));
   assign wr_value  = sat ? (sum_val[SUM_W-1] ? Q_MIN : Q_MAX) : sum_val[VALUE_W-1:0];

   always_comb begin
      rsp_valid_in = ctl.read_out | ctl.apply;
      rsp_data_in  = rsp_data_ff;
      if (ctl.read_out) begin
         rsp_data_in.entry_value = rd_data;
         rsp_data_in.saturated   = 1'b0;
      end else if (ctl.apply) begin
         rsp_data_in.entry_value = wr_value;
         rsp_data_in.saturated   = sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (ctl.load) begin
         reward_ff <= reward_value;
      end
      if (ctl.take_cur) begin
         cur_ff  <= rd_data;
         best_ff <= '0;
      end else if (ctl.fold) begin
         best_ff <= best_in;
      end
      if (ctl.scale) begin
         gprod_ff <= gprod_in;
      end
      if (ctl.diff) begin
         diff_ff <= diff_in;
      end
      if (ctl.mult) begin
         aprod_ff <= aprod_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ sv/tabular_q_learning_update_top.sv @@
// update request: result strobe once the next-state row has been read one entry per cycle
//   through the single ram read port and passed through the two multiply stages; no new
//   request is taken while busy, and busy drops with the result strobe
// read request: the result strobe carries the entry as read; busy drops with the result strobe
// reset (synchronous) zeroes all STATE_COUNT*ACTION_COUNT entries of the q table in a sweep
//   (64 by default) with busy high; csr writes are taken throughout; results cannot be stalled
module tabular_q_learning_update_top #(
   parameter int STATE_COUNT  = tqlu_pkg::STATE_COUNT_DEF,
   parameter int ACTION_COUNT = tqlu_pkg::ACTION_COUNT_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  tqlu_pkg::req_type             req_data,
   output logic                          rsp_valid,
   output tqlu_pkg::rsp_type             rsp_data,
   input  logic                          csr_we,
   input  tqlu_pkg::csr_index_type       csr_index,
   input  logic [tqlu_pkg::CFG_W-1:0]    csr_wdata
);

   import tqlu_pkg::*;

   localparam int DEPTH  = STATE_COUNT * ACTION_COUNT;
   localparam int ADDR_W = $clog2(DEPTH);

   logic [CFG_W-1:0]   alpha_ff, alpha_in;
   logic [CFG_W-1:0]   gamma_ff, gamma_in;

   ctl_type            ctl;
   logic [ADDR_W-1:0]  rd_addr;
   logic [ADDR_W-1:0]  wr_addr;
   logic               wr_en;
   logic [VALUE_W-1:0] wr_data;
   logic [VALUE_W-1:0] wr_value;
   logic [VALUE_W-1:0] rd_data;

   always_comb begin
      alpha_in = alpha_ff;
      gamma_in = gamma_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_LEARNING_RATE:   alpha_in = csr_wdata;
            CSR_DISCOUNT_FACTOR: gamma_in = csr_wdata;
            default: begin
               alpha_in = alpha_ff;
               gamma_in = gamma_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff <= LEARNING_RATE_RESET;
         gamma_ff <= DISCOUNT_FACTOR_RESET;
      end else begin
         alpha_ff <= alpha_in;
         gamma_ff <= gamma_in;
      end
   end

   tqlu_seq #(
      .STATE_COUNT  (STATE_COUNT),
      .ACTION_COUNT (ACTION_COUNT)
   ) u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_data (req_data),
      .busy     (busy),
      .ctl      (ctl),
      .rd_addr  (rd_addr),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr)
   );

   assign wr_data = ctl.clearing ? '0 : wr_value;

   tqlu_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (DEPTH)
   ) u_qtab (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   tqlu_arith u_arith (
      .clock           (clock),
      .reset           (reset),
      .ctl             (ctl),
      .reward_value    (req_data.reward_value),
      .rd_data         (rd_data),
      .learning_rate   (alpha_ff),
      .discount_factor (gamma_ff),
      .wr_value        (wr_value),
      .rsp_valid       (rsp_valid),
      .rsp_data        (rsp_data)
   );

endmodule

@@ sv/tqlu_checker.sv @@
`include "tabular_q_learning_update_top_macros.svh"

module tqlu_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input tqlu_pkg::req_type req_data,
   input logic              rsp_valid,
   input tqlu_pkg::rsp_type rsp_data
);

   import tqlu_pkg::*;

   // a result always comes out of a working cycle
   `TQLU_ASSERT(a_rsp_after_busy, rsp_valid |-> $past(busy), "result without work in progress")

   `TQLU_ASSERT(a_rsp_single, rsp_valid |=> !rsp_valid, "result strobe held two cycles")

   `TQLU_ASSERT(a_take_sets_busy, (start && !busy) |=> busy, "request taken but block not busy")

   // read requests get a result strobe that never flags clipping
   `TQLU_ASSERT(a_read_answer, (start && !busy && (req_data.command == CMD_READ)) |=> ##1 (rsp_valid && !rsp_data.saturated), "read request not answered in time")

   // table clear keeps the block busy straight after reset
   `TQLU_ASSERT_ALWAYS(a_clear_busy, $fell(reset) |-> busy, "not busy while clearing the table")

endmodule

bind tabular_q_learning_update_top tqlu_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);

@@ dv/q_update_checker.sv @@
`timescale 1ns / 1ps

module q_update_checker
   import tqlu_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                busy,
   input  req_type             req_data,
   input  logic                rsp_valid,
   input  rsp_type             rsp_data,
   input  logic                csr_we,
   input  csr_index_type       csr_index,
   input  logic [CFG_W-1:0]    csr_wdata,
   output int                  mismatch_count,
   output int                  outstanding_count
);

   localparam int ENTRY_COUNT = STATE_COUNT_DEF * ACTION_COUNT_DEF;

   logic signed [VALUE_W-1:0] q_table [ENTRY_COUNT];
   logic [CFG_W-1:0]          alpha_q16;
   logic [CFG_W-1:0]          gamma_q16;
   rsp_type                   expected_entries [$];
   rsp_type                   oldest;

   // nearest, ties toward plus infinity
   function automatic longint round_q16(longint x);
      return (x + ROUND_HALF) >>> FRAC_W;
   endfunction

   function automatic rsp_type apply_experience(req_type r);
      int      idx;
      int      row;
      int      b;
      longint  cur;
      longint  best;
      longint  g;
      longint  d;
      longint  nxt;
      longint  v;
      rsp_type res;
      idx = (int'(r.current_state) % STATE_COUNT_DEF) * ACTION_COUNT_DEF
            + int'(r.chosen_action) % ACTION_COUNT_DEF;
      cur = longint'(q_table[idx]);
      res.saturated   = 1'b0;
      res.entry_value = q_table[idx];
      if (r.command == CMD_READ) begin
         return res;
      end
      // best of the next row, floored at zero, taken before the write
      row  = (int'(r.following_state) % STATE_COUNT_DEF) * ACTION_COUNT_DEF;
      best = 0;
      for (b = 0; b < ACTION_COUNT_DEF; b++) begin
         v = longint'(q_table[row + b]);
         if (v > best) begin
            best = v;
         end
      end
      g   = round_q16(longint'(gamma_q16) * best);
      d   = longint'(r.reward_value) + g - cur;
      nxt = cur + round_q16(longint'(alpha_q16) * d);
      if (nxt > longint'(signed'(Q_MAX))) begin
         nxt = longint'(signed'(Q_MAX));
         res.saturated = 1'b1;
      end else if (nxt < longint'(signed'(Q_MIN))) begin
         nxt = longint'(signed'(Q_MIN));
         res.saturated = 1'b1;
      end
      q_table[idx]    = nxt[VALUE_W-1:0];
      res.entry_value = nxt[VALUE_W-1:0];
      return res;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         foreach (q_table[i]) begin
            q_table[i] = '0;
         end
         alpha_q16 = LEARNING_RATE_RESET;
         gamma_q16 = DISCOUNT_FACTOR_RESET;
         expected_entries.delete();
         mismatch_count = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_LEARNING_RATE: begin
                  alpha_q16 = csr_wdata;
               end
               CSR_DISCOUNT_FACTOR: begin
                  gamma_q16 = csr_wdata;
               end
               default: begin
               end
            endcase
         end
         // a result never comes in the cycle of its own request, so check first
         if (rsp_valid) begin
            if (expected_entries.size() == 0) begin
               $error("unexpected result: entry_value %0d saturated %0b",
                      rsp_data.entry_value, rsp_data.saturated);
               mismatch_count++;
            end else begin
               oldest = expected_entries.pop_front();
               if (rsp_data.entry_value !== oldest.entry_value) begin
                  $error("entry_value: expected %0d, actual %0d",
                         oldest.entry_value, rsp_data.entry_value);
                  mismatch_count++;
               end
               if (rsp_data.saturated !== oldest.saturated) begin
                  $error("saturated: expected %0b, actual %0b",
                         oldest.saturated, rsp_data.saturated);
                  mismatch_count++;
               end
            end
         end
         if (start && !busy) begin
            expected_entries.push_back(apply_experience(req_data));
         end
      end
      outstanding_count = expected_entries.size();
   end

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
   import tqlu_pkg::*;

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   req_type             req_data;
   logic                rsp_valid;
   rsp_type             rsp_data;
   logic                csr_we;
   csr_index_type       csr_index;
   logic [CFG_W-1:0]    csr_wdata;
   int                  mismatch_count;
   int                  outstanding_count;
   int                  idle_pct;
   int                  tail_cycles;

   tabular_q_learning_update_top u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   q_update_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_data          (req_data),
      .rsp_valid         (rsp_valid),
      .rsp_data          (rsp_data),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .mismatch_count    (mismatch_count),
      .outstanding_count (outstanding_count)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   function automatic req_type make_request(cmd_type cmd, int s, int a, logic [31:0] r, int n);
      req_type req;
      req.command         = cmd;
      req.current_state   = STATE_W'(s);
      req.chosen_action   = ACTION_W'(a);
      req.reward_value    = r;
      req.following_state = STATE_W'(n);
      return req;
   endfunction

   function automatic req_type random_experience();
      req_type req;
      req.command = ($urandom_range(99) < 25) ? CMD_READ : CMD_UPDATE;
      // keep most traffic on a few rows so that values build up
      if ($urandom_range(99) < 60) begin
         req.current_state = STATE_W'($urandom_range(3));
      end else begin
         req.current_state = STATE_W'($urandom_range(STATE_COUNT_DEF - 1));
      end
      req.chosen_action = ACTION_W'($urandom_range(ACTION_COUNT_DEF - 1));
      case ($urandom_range(3))
         0: req.reward_value = $urandom();
         1: req.reward_value = $urandom_range(32'h0010_0000) - 32'h0008_0000;
         2: req.reward_value = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: req.reward_value = ($urandom_range(64) - 32) << FRAC_W;
      endcase
      case ($urandom_range(3))
         0: req.following_state = req.current_state;
         1: req.following_state = STATE_W'(req.current_state + 1);
         default: req.following_state = STATE_W'($urandom_range(STATE_COUNT_DEF - 1));
      endcase
      return req;
   endfunction

   task automatic issue_request(req_type req);
      if ($urandom_range(99) < idle_pct) begin
         repeat ($urandom_range(1, 12)) begin
            @(negedge clock);
            start <= 1'b0;
         end
      end
      @(negedge clock);
      start    <= 1'b1;
      req_data <= req;
      do @(posedge clock); while (busy);
   endtask

   task automatic drain();
      @(negedge clock);
      start <= 1'b0;
      while (outstanding_count != 0 || busy) begin
         @(negedge clock);
      end
   endtask

   task automatic write_csr(csr_index_type idx, logic [CFG_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic run_phase(logic [CFG_W-1:0] alpha, logic [CFG_W-1:0] gamma, int pct, int count);
      drain();
      write_csr(CSR_LEARNING_RATE, alpha);
      write_csr(CSR_DISCOUNT_FACTOR, gamma);
      idle_pct = pct;
      repeat (count) begin
         issue_request(random_experience());
      end
   endtask

   initial begin
      reset     = 1'b1;
      start     = 1'b0;
      req_data  = '0;
      csr_we    = 1'b0;
      csr_index = CSR_LEARNING_RATE;
      csr_wdata = '0;
      idle_pct  = 0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // directed part at the reset defaults
      issue_request(make_request(CMD_READ,   0, 0, 32'h0,         0));
      issue_request(make_request(CMD_UPDATE, 0, 0, 32'h0001_0000, 1));
      issue_request(make_request(CMD_READ,   0, 0, 32'h0,         0));
      issue_request(make_request(CMD_UPDATE, 15, 3, 32'h7FFF_FFFF, 15));
      issue_request(make_request(CMD_UPDATE, 15, 3, 32'h7FFF_FFFF, 15));
      // drive the whole of row 1 negative, then update from it
      issue_request(make_request(CMD_UPDATE, 1, 0, 32'h8000_0000, 1));
      issue_request(make_request(CMD_UPDATE, 1, 1, 32'h8000_0000, 1));
      issue_request(make_request(CMD_UPDATE, 1, 2, 32'h8000_0000, 1));
      issue_request(make_request(CMD_UPDATE, 1, 3, 32'h8000_0000, 1));
      issue_request(make_request(CMD_UPDATE, 2, 1, 32'h0,         1));
      issue_request(make_request(CMD_READ,   1, 3, 32'hFFFF_FFFF, 15));

      // full-scale rates push the self-referencing entry into clipping
      drain();
      write_csr(CSR_LEARNING_RATE, 16'hFFFF);
      write_csr(CSR_DISCOUNT_FACTOR, 16'hFFFF);
      repeat (4) begin
         issue_request(make_request(CMD_UPDATE, 15, 3, 32'h7FFF_FFFF, 15));
      end
      issue_request(make_request(CMD_READ,   15, 3, 32'h0,         0));
      issue_request(make_request(CMD_UPDATE, 14, 0, 32'h8000_0000, 1));
      issue_request(make_request(CMD_UPDATE, 14, 0, 32'h8000_0000, 1));

      drain();
      write_csr(CSR_LEARNING_RATE, 16'h0000);
      write_csr(CSR_DISCOUNT_FACTOR, 16'h0000);
      issue_request(make_request(CMD_UPDATE, 15, 3, 32'h8000_0000, 15));
      issue_request(make_request(CMD_READ,   15, 3, 32'h0,         0));

      // random part
      run_phase(16'hFFFF, 16'hFFFF, 0, 200);
      run_phase(16'h0000, 16'h0000, 64, 200);
      run_phase(CFG_W'($urandom()), CFG_W'($urandom()), 10, 300);
      run_phase(LEARNING_RATE_RESET, DISCOUNT_FACTOR_RESET, 64, 300);
      run_phase(16'h0001, 16'hFFFF, 0, 200);
      run_phase(CFG_W'($urandom()), CFG_W'($urandom()), 10, 400);

      @(negedge clock);
      start <= 1'b0;
      tail_cycles = 0;
      while (outstanding_count != 0 && tail_cycles < 1000) begin
         @(negedge clock);
         tail_cycles++;
      end
      repeat (20) @(negedge clock);
      if (mismatch_count == 0 && outstanding_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
